FILE: design/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// shared types and codes of the fractional max pooling block
// ----------------------------------------------------------------------------
`default_nettype none

package fmp_pkg;

  // request codes
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_IN_H   = 3'd0;
  localparam logic [2:0] CFG_IN_W   = 3'd1;
  localparam logic [2:0] CFG_OUT_H  = 3'd2;
  localparam logic [2:0] CFG_OUT_W  = 3'd3;
  localparam logic [2:0] CFG_POOL_H = 3'd4;
  localparam logic [2:0] CFG_POOL_W = 3'd5;

  localparam int IDX_BITS  = 13;
  localparam int WIN_BITS  = 13;
  localparam int STEP_BITS = 22;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COORD = 2'd1,
    ST_SIZE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0] in_h;
    logic [6:0] in_w;
    logic [6:0] out_h;
    logic [6:0] out_w;
    logic [4:0] pool_h;
    logic [4:0] pool_w;
  } cfg_t;

  // descriptor of one queued job
  typedef struct packed {
    logic                is_query;
    status_e             status;
    logic [WIN_BITS-1:0] h0;
    logic [WIN_BITS-1:0] w0;
  } desc_t;

endpackage

`default_nettype wire

FILE: design/fmp_ram.sv
// ----------------------------------------------------------------------------
// fmp_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/fmp_queue.sv
// ----------------------------------------------------------------------------
// fmp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/fmp_front.sv
// ----------------------------------------------------------------------------
// fmp_front
// accepts requests, computes steps and window starts, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_front #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_POOL   = 16,
  parameter int VALUE_BITS = 16,
  parameter int AW         = 12,
  parameter int QW         = 57
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fmp_pkg::cfg_t         cfg_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [15:0]           sample_w_i,
  input  wire logic [15:0]           sample_h_i,
  input  wire logic [5:0]            row_pos_i,
  input  wire logic [5:0]            col_pos_i,
  input  wire logic [VALUE_BITS-1:0] pix_value_i,
  output      logic                  q_push_o,
  output      logic [QW-1:0]         q_data_o,
  input  wire logic                  q_full_i
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_MUL, F_PUSH} state_e;

  state_e state_q;
  logic [15:0] off_w_q, off_h_q;
  logic [fmp_pkg::STEP_BITS-1:0] step_w_q, step_h_q;
  logic [4:0] cnt_q;
  logic [5:0] row_q, col_q;
  logic is_query_q;
  fmp_pkg::status_e status_q;
  logic [AW-1:0] addr_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [43:0] prod_q;
  logic [11:0] hi_ha_q, hi_hb_q, hi_wa_q, hi_wb_q;

  // divider state, one axis per set
  logic [22:0] num_h_q, num_w_q, quo_h_q, quo_w_q;
  logic [7:0]  rem_h_q, rem_w_q;
  logic [6:0]  den_h_q, den_w_q;
  logic        zero_h_q, zero_w_q;

  logic [7:0]  rsh_h, rsh_w, rem_h_d, rem_w_d;
  logic        ge_h, ge_w;
  logic [21:0] mul_a, mul_b;
  logic [43:0] mul_p;
  logic        accept, sizes_bad;
  logic [7:0]  span_h, span_w;
  fmp_pkg::desc_t desc;

  assign in_stall_o = state_q != F_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    rsh_h   = {rem_h_q[6:0], num_h_q[22]};
    rsh_w   = {rem_w_q[6:0], num_w_q[22]};
    ge_h    = rsh_h >= {1'b0, den_h_q};
    ge_w    = rsh_w >= {1'b0, den_w_q};
    rem_h_d = ge_h ? rsh_h - {1'b0, den_h_q} : rsh_h;
    rem_w_d = ge_w ? rsh_w - {1'b0, den_w_q} : rsh_w;
  end

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin mul_a = {row_q, off_h_q};  mul_b = step_h_q; end
      2'd1: begin mul_a = {6'd0, off_h_q};   mul_b = step_h_q; end
      2'd2: begin mul_a = {col_q, off_w_q};  mul_b = step_w_q; end
      default: begin mul_a = {6'd0, off_w_q}; mul_b = step_w_q; end
    endcase
  end
  assign mul_p = 44'(mul_a) * 44'(mul_b);

  always_comb begin
    span_h    = 8'(cfg_i.out_h) + 8'(cfg_i.pool_h) - 8'd1;
    span_w    = 8'(cfg_i.out_w) + 8'(cfg_i.pool_w) - 8'd1;
    sizes_bad = (cfg_i.in_h == 7'd0) || (cfg_i.in_h > 7'd64)
             || (32'(cfg_i.in_h) > MAX_ROWS)
             || (cfg_i.in_w == 7'd0) || (cfg_i.in_w > 7'd64)
             || (32'(cfg_i.in_w) > MAX_COLS)
             || (cfg_i.out_h == 7'd0) || (cfg_i.out_h > 7'd64)
             || (cfg_i.out_w == 7'd0) || (cfg_i.out_w > 7'd64)
             || (cfg_i.pool_h == 5'd0) || (cfg_i.pool_h > 5'd16)
             || (32'(cfg_i.pool_h) > MAX_POOL)
             || (cfg_i.pool_w == 5'd0) || (cfg_i.pool_w > 5'd16)
             || (32'(cfg_i.pool_w) > MAX_POOL)
             || (span_h > 8'(cfg_i.in_h)) || (span_w > 8'(cfg_i.in_w));
  end

  // window start, last output position pinned to in - pool
  always_comb begin
    desc.is_query = is_query_q;
    desc.status   = status_q;
    if ({1'b0, row_q} == cfg_i.out_h - 7'd1) begin
      desc.h0 = 13'(cfg_i.in_h - 7'(cfg_i.pool_h));
    end else begin
      desc.h0 = 13'(hi_ha_q - hi_hb_q);
    end
    if ({1'b0, col_q} == cfg_i.out_w - 7'd1) begin
      desc.w0 = 13'(cfg_i.in_w - 7'(cfg_i.pool_w));
    end else begin
      desc.w0 = 13'(hi_wa_q - hi_wb_q);
    end
  end

  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o = {desc, addr_q, value_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      off_w_q    <= '0;
      off_h_q    <= '0;
      step_w_q   <= '0;
      step_h_q   <= '0;
      cnt_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      is_query_q <= 1'b0;
      status_q   <= fmp_pkg::ST_OK;
      addr_q     <= '0;
      value_q    <= '0;
      prod_q     <= '0;
      hi_ha_q    <= '0;
      hi_hb_q    <= '0;
      hi_wa_q    <= '0;
      hi_wb_q    <= '0;
      num_h_q    <= '0;
      num_w_q    <= '0;
      quo_h_q    <= '0;
      quo_w_q    <= '0;
      rem_h_q    <= '0;
      rem_w_q    <= '0;
      den_h_q    <= '0;
      den_w_q    <= '0;
      zero_h_q   <= 1'b0;
      zero_w_q   <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            row_q   <= row_pos_i;
            col_q   <= col_pos_i;
            value_q <= pix_value_i;
            addr_q  <= AW'(32'(row_pos_i) * MAX_COLS + 32'(col_pos_i));
            cnt_q   <= '0;
            unique case (req_type_i)
              fmp_pkg::REQ_SAMPLE: begin
                off_w_q  <= sample_w_i;
                off_h_q  <= sample_h_i;
                num_h_q  <= {cfg_i.in_h - 7'(cfg_i.pool_h), 16'd0};
                num_w_q  <= {cfg_i.in_w - 7'(cfg_i.pool_w), 16'd0};
                den_h_q  <= cfg_i.out_h - 7'd1;
                den_w_q  <= cfg_i.out_w - 7'd1;
                zero_h_q <= (cfg_i.out_h < 7'd2) || (cfg_i.in_h < 7'(cfg_i.pool_h));
                zero_w_q <= (cfg_i.out_w < 7'd2) || (cfg_i.in_w < 7'(cfg_i.pool_w));
                rem_h_q  <= '0;
                rem_w_q  <= '0;
                quo_h_q  <= '0;
                quo_w_q  <= '0;
                state_q  <= F_DIV;
              end
              fmp_pkg::REQ_PIXEL: begin
                is_query_q <= 1'b0;
                status_q   <= fmp_pkg::ST_OK;
                if ((32'(row_pos_i) < MAX_ROWS) && (32'(col_pos_i) < MAX_COLS)) begin
                  state_q <= F_PUSH;
                end
              end
              fmp_pkg::REQ_QUERY: begin
                is_query_q <= 1'b1;
                if (sizes_bad) begin
                  status_q <= fmp_pkg::ST_SIZE;
                  state_q  <= F_PUSH;
                end else if (({1'b0, row_pos_i} >= cfg_i.out_h)
                          || ({1'b0, col_pos_i} >= cfg_i.out_w)) begin
                  status_q <= fmp_pkg::ST_COORD;
                  state_q  <= F_PUSH;
                end else begin
                  status_q <= fmp_pkg::ST_OK;
                  state_q  <= F_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        F_DIV: begin
          rem_h_q <= rem_h_d;
          rem_w_q <= rem_w_d;
          num_h_q <= {num_h_q[21:0], 1'b0};
          num_w_q <= {num_w_q[21:0], 1'b0};
          quo_h_q <= {quo_h_q[21:0], ge_h};
          quo_w_q <= {quo_w_q[21:0], ge_w};
          if (cnt_q == 5'd22) begin
            step_h_q <= zero_h_q ? '0 : {quo_h_q[20:0], ge_h};
            step_w_q <= zero_w_q ? '0 : {quo_w_q[20:0], ge_w};
            state_q  <= F_IDLE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        F_MUL: begin
          prod_q <= mul_p;
          unique case (cnt_q)
            5'd1:    hi_ha_q <= prod_q[43:32];
            5'd2:    hi_hb_q <= prod_q[43:32];
            5'd3:    hi_wa_q <= prod_q[43:32];
            5'd4:    hi_wb_q <= prod_q[43:32];
            default: begin
            end
          endcase
          if (cnt_q == 5'd4) begin
            state_q <= F_PUSH;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: begin
          if (!q_full_i) state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/fmp_back.sv
// ----------------------------------------------------------------------------
// fmp_back
// executes pixel writes and window scans against the plane store
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_back #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16,
  parameter int AW         = 12,
  parameter int QW         = 57
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire fmp_pkg::cfg_t          cfg_i,
  input  wire logic                   q_empty_i,
  input  wire logic [QW-1:0]          q_data_i,
  output      logic                   q_pop_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic [VALUE_BITS-1:0]  max_value_o,
  output      logic [fmp_pkg::IDX_BITS-1:0] max_index_o,
  output      logic [1:0]             status_o
);

  localparam int DW = $bits(fmp_pkg::desc_t);
  localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DRAIN, B_DONE} state_e;

  state_e state_q;
  logic [fmp_pkg::WIN_BITS-1:0] h0_q, w0_q;
  logic [4:0] i_q, j_q;
  logic rdv_q;
  logic [fmp_pkg::IDX_BITS-1:0] idx_q, bidx_q;
  logic [VALUE_BITS-1:0] best_q;
  logic out_valid_q;

  fmp_pkg::desc_t desc;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic [fmp_pkg::WIN_BITS-1:0] h, w;
  logic in_range, last, gt;
  logic [fmp_pkg::IDX_BITS-1:0] idx_d;

  assign desc  = fmp_pkg::desc_t'(q_data_i[QW-1 -: DW]);
  assign waddr = q_data_i[AW+VALUE_BITS-1 -: AW];
  assign wdata = q_data_i[VALUE_BITS-1:0];

  assign h        = h0_q + fmp_pkg::WIN_BITS'(i_q);
  assign w        = w0_q + fmp_pkg::WIN_BITS'(j_q);
  assign in_range = (h < fmp_pkg::WIN_BITS'(cfg_i.in_h)) && (w < fmp_pkg::WIN_BITS'(cfg_i.in_w));
  assign raddr    = AW'(32'(h) * MAX_COLS + 32'(w));
  assign idx_d    = fmp_pkg::IDX_BITS'(14'(h[6:0]) * 14'(cfg_i.in_w) + 14'(w[6:0]));
  assign last     = (i_q == cfg_i.pool_h - 5'd1) && (j_q == cfg_i.pool_w - 5'd1);
  assign gt       = $signed(rdata) > $signed(best_q);

  assign q_pop_o = (state_q == B_IDLE) && !q_empty_i && (!desc.is_query || !out_valid_q);
  assign out_valid_o = out_valid_q;

  fmp_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ROWS * MAX_COLS)
  ) u_plane (
    .clk_i  (clk_i),
    .we_i   (q_pop_o && !desc.is_query),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      h0_q        <= '0;
      w0_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      rdv_q       <= 1'b0;
      idx_q       <= '0;
      bidx_q      <= '1;
      best_q      <= MOST_NEG;
      out_valid_q <= 1'b0;
      max_value_o <= '0;
      max_index_o <= '0;
      status_o    <= fmp_pkg::ST_OK;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      rdv_q <= (state_q == B_SCAN) && in_range;
      idx_q <= idx_d;
      if (rdv_q && gt) begin
        best_q <= rdata;
        bidx_q <= idx_q;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_pop_o && desc.is_query) begin
            if (desc.status != fmp_pkg::ST_OK) begin
              max_value_o <= MOST_NEG;
              max_index_o <= '1;
              status_o    <= desc.status;
              out_valid_q <= 1'b1;
            end else begin
              h0_q    <= desc.h0;
              w0_q    <= desc.w0;
              i_q     <= '0;
              j_q     <= '0;
              best_q  <= MOST_NEG;
              bidx_q  <= '1;
              state_q <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          if (j_q == cfg_i.pool_w - 5'd1) begin
            j_q <= '0;
            i_q <= i_q + 5'd1;
          end else begin
            j_q <= j_q + 5'd1;
          end
          if (last) state_q <= B_DRAIN;
        end
        B_DRAIN: begin
          state_q <= B_DONE;
        end
        default: begin
          max_value_o <= best_q;
          max_index_o <= bidx_q;
          status_o    <= fmp_pkg::ST_OK;
          out_valid_q <= 1'b1;
          state_q     <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/fractional_max_pool_2d.sv
// ----------------------------------------------------------------------------
// fractional_max_pool_2d
// fractional max pooling of one feature plane held in an on-chip store
// ----------------------------------------------------------------------------
// Three request kinds arrive on the input channel: a sample beat sets the
// Q0.16 offsets and recomputes both Q6.16 steps, a pixel beat writes one
// plane word, a query beat returns the window maximum, its row-major index
// (-1 if nothing beats the most negative value) and a status. A front end
// takes the beat and prepares the job; a two-entry queue hands it to a back
// end that owns the plane store, so the front can take the next beat while
// a window is being scanned or a result waits on the output. A sample beat
// holds the front while two 23-step restoring dividers run side by side. A
// query passes the front, where one shared 22x22 multiplier makes four
// products, then the back, which reads the store once per window element,
// compares the last word and loads the output register. A pixel beat passes
// the front and is written into the store by the back. A result beat on the
// output holds off the next query pop until it has left. The store has no
// reset; reading a word never written returns whatever it holds.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_max_pool_2d #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_POOL   = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [6:0]            cfg_data_i,
  // request channel
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [15:0]           sample_w_i,
  input  wire logic [15:0]           sample_h_i,
  input  wire logic [5:0]            row_pos_i,
  input  wire logic [5:0]            col_pos_i,
  input  wire logic [VALUE_BITS-1:0] pix_value_i,
  // result channel
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [VALUE_BITS-1:0] max_value_o,
  output      logic [12:0]           max_index_o,
  output      logic [1:0]            status_o
);

  // store address width and queue entry width
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int QW = $bits(fmp_pkg::desc_t) + AW + VALUE_BITS;

  fmp_pkg::cfg_t cfg_q;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_h   <= 7'd64;
      cfg_q.in_w   <= 7'd64;
      cfg_q.out_h  <= 7'd32;
      cfg_q.out_w  <= 7'd32;
      cfg_q.pool_h <= 5'd2;
      cfg_q.pool_w <= 5'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmp_pkg::CFG_IN_H:   cfg_q.in_h   <= cfg_data_i;
        fmp_pkg::CFG_IN_W:   cfg_q.in_w   <= cfg_data_i;
        fmp_pkg::CFG_OUT_H:  cfg_q.out_h  <= cfg_data_i;
        fmp_pkg::CFG_OUT_W:  cfg_q.out_w  <= cfg_data_i;
        fmp_pkg::CFG_POOL_H: cfg_q.pool_h <= cfg_data_i[4:0];
        fmp_pkg::CFG_POOL_W: cfg_q.pool_w <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify the beat, steps and window starts
  fmp_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_POOL  (MAX_POOL),
    .VALUE_BITS(VALUE_BITS),
    .AW        (AW),
    .QW        (QW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sample_w_i (sample_w_i),
    .sample_h_i (sample_h_i),
    .row_pos_i  (row_pos_i),
    .col_pos_i  (col_pos_i),
    .pix_value_i(pix_value_i),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  // job queue keeps writes and queries in arrival order
  fmp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  // back: plane store, window scan, output register
  fmp_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS),
    .AW        (AW),
    .QW        (QW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .max_value_o(max_value_o),
    .max_index_o(max_index_o),
    .status_o   (status_o)
  );

endmodule

`default_nettype wire

FILE: design/fmp_checker.sv
// ----------------------------------------------------------------------------
// fmp_checker
// port-level checks of the fractional max pooling block
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_checker #(
  parameter int VALUE_BITS = 16
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [VALUE_BITS-1:0] max_value_o,
  input wire logic [12:0]           max_index_o,
  input wire logic [1:0]            status_o
);

  localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_value_o)
      && $stable(max_index_o) && $stable(status_o))
    else $error("result beat changed under stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // errored results carry no maximum
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != fmp_pkg::ST_OK |->
      max_index_o == 13'h1fff && max_value_o == MOST_NEG)
    else $error("error result carries data");

  // a found index lies inside a 64x64 plane
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && max_index_o != 13'h1fff |-> !max_index_o[12])
    else $error("index out of plane");

  // no maximum found means the most negative value
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && max_index_o == 13'h1fff |-> max_value_o == MOST_NEG)
    else $error("value without index");

endmodule

bind fractional_max_pool_2d fmp_checker #(.VALUE_BITS(VALUE_BITS)) u_fmp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .max_value_o(max_value_o),
  .max_index_o(max_index_o),
  .status_o   (status_o)
);

`default_nettype wire

FILE: sim/fmp_checker.sv
// ----------------------------------------------------------------------------
// fmp_scoreboard
// watches both channels of the pooling block, predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fmp_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] sample_w_i,
  input  logic [15:0] sample_h_i,
  input  logic [5:0]  row_pos_i,
  input  logic [5:0]  col_pos_i,
  input  logic [15:0] pix_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] max_value_i,
  input  logic [12:0] max_index_i,
  input  logic [1:0]  status_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [15:0]       value;
    logic [12:0]       index;
    fmp_pkg::status_e  status;
  } pooled_t;

  pooled_t       pooled_q[$];
  fmp_pkg::cfg_t sizes;
  logic [15:0]   plane [4096];
  int unsigned   ofs_w, ofs_h, step_w, step_h;

  function automatic int unsigned calc_step(int unsigned n_in, int unsigned n_out,
                                            int unsigned n_pool);
    longint unsigned q;
    if (n_out < 2 || n_in < n_pool) return 0;
    q = (longint'(n_in - n_pool) << 16) / longint'(n_out - 1);
    return 32'(q & 64'h3F_FFFF);
  endfunction

  function automatic int unsigned win_start(int unsigned ofs, int unsigned step,
                                            int unsigned idx, int unsigned n_in,
                                            int unsigned n_out, int unsigned n_pool);
    longint unsigned a, b;
    if (idx == n_out - 1) return n_in - n_pool;
    a = ((longint'(idx) << 16) + longint'(ofs)) * longint'(step);
    b = longint'(ofs) * longint'(step);
    return 32'((a >> 32) - (b >> 32));
  endfunction

  function automatic bit sizes_bad();
    int ih, iw, oh, ow, ph, pw;
    ih = int'(sizes.in_h); iw = int'(sizes.in_w); oh = int'(sizes.out_h);
    ow = int'(sizes.out_w); ph = int'(sizes.pool_h); pw = int'(sizes.pool_w);
    if (ih < 1 || ih > 64 || iw < 1 || iw > 64) return 1;
    if (oh < 1 || oh > 64 || ow < 1 || ow > 64) return 1;
    if (ph < 1 || ph > 16 || pw < 1 || pw > 16) return 1;
    if (oh + ph - 1 > ih || ow + pw - 1 > iw) return 1;
    return 0;
  endfunction

  function automatic pooled_t pool_window(int unsigned row, int unsigned col);
    pooled_t     r;
    int          best, best_idx, v;
    int unsigned h0, w0, h, w;
    best = -32768;
    best_idx = -1;
    r.status = fmp_pkg::ST_OK;
    if (sizes_bad()) begin
      r.status = fmp_pkg::ST_SIZE;
    end else if (row >= sizes.out_h || col >= sizes.out_w) begin
      r.status = fmp_pkg::ST_COORD;
    end else begin
      h0 = win_start(ofs_h, step_h, row, sizes.in_h, sizes.out_h, sizes.pool_h);
      w0 = win_start(ofs_w, step_w, col, sizes.in_w, sizes.out_w, sizes.pool_w);
      for (int i = 0; i < sizes.pool_h; i++) begin
        h = h0 + i;
        if (h >= sizes.in_h) continue;
        for (int j = 0; j < sizes.pool_w; j++) begin
          w = w0 + j;
          if (w >= sizes.in_w) continue;
          v = int'($signed(plane[h * 64 + w]));
          if (v > best) begin
            best = v;
            best_idx = int'(h * sizes.in_w + w);
          end
        end
      end
    end
    r.value = best[15:0];
    r.index = best_idx[12:0];
    return r;
  endfunction

  assign pending_o = pooled_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t exp_r;
    if (!rst_ni) begin
      sizes <= '{in_h: 64, in_w: 64, out_h: 32, out_w: 32, pool_h: 2, pool_w: 2};
      ofs_w <= 0; ofs_h <= 0; step_w <= 0; step_h <= 0;
      errors_o <= 0;
      pooled_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fmp_pkg::CFG_IN_H:   sizes.in_h   <= cfg_data_i;
          fmp_pkg::CFG_IN_W:   sizes.in_w   <= cfg_data_i;
          fmp_pkg::CFG_OUT_H:  sizes.out_h  <= cfg_data_i;
          fmp_pkg::CFG_OUT_W:  sizes.out_w  <= cfg_data_i;
          fmp_pkg::CFG_POOL_H: sizes.pool_h <= cfg_data_i[4:0];
          fmp_pkg::CFG_POOL_W: sizes.pool_w <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_type_i)
          fmp_pkg::REQ_SAMPLE: begin
            ofs_w  <= 32'(sample_w_i);
            ofs_h  <= 32'(sample_h_i);
            step_w <= calc_step(32'(sizes.in_w), 32'(sizes.out_w), 32'(sizes.pool_w));
            step_h <= calc_step(32'(sizes.in_h), 32'(sizes.out_h), 32'(sizes.pool_h));
          end
          fmp_pkg::REQ_PIXEL: plane[{row_pos_i, col_pos_i}] = pix_value_i;
          fmp_pkg::REQ_QUERY: pooled_q.push_back(pool_window(32'(row_pos_i),
                                                             32'(col_pos_i)));
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pooled_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %0d index %0d status %0d",
                   $time, $signed(max_value_i), $signed(max_index_i), status_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = pooled_q.pop_front();
          if (max_value_i !== exp_r.value || max_index_i !== exp_r.index ||
              status_i !== exp_r.status) begin
            $display("%0t: mismatch expected value %0d index %0d status %0d, got %0d %0d %0d",
                     $time, $signed(exp_r.value), $signed(exp_r.index), exp_r.status,
                     $signed(max_value_i), $signed(max_index_i), status_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the fractional max pooling block
// ----------------------------------------------------------------------------
// The top-left 32x32 corner of the plane store is filled first, and every
// valid size set keeps the input plane inside that corner, so no query can
// read an unwritten word. A directed run on a 32x32 plane follows, then a
// series of phases, each with its own sizes (extremes, bad sizes, stale
// steps) and its own idling mix, made of a sample beat and mostly queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, block ignores it
  localparam int STALL_LIMIT = 20000;       // cycles with no beat at all
  localparam int DRAIN_WAIT  = 300;         // covers a 16x16 window scan
  localparam int FILL_SIZE   = 32;          // filled corner of the store

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [6:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  req_type;
  logic [15:0] sample_w, sample_h, pix_value;
  logic [5:0]  row_pos, col_pos;
  logic        out_valid, out_stall;
  logic [15:0] max_value;
  logic [12:0] max_index;
  logic [1:0]  status;
  int          errors, pending;
  int          idle_pct, stall_pct, quiet;
  int unsigned cur_oh, cur_ow;

  fractional_max_pool_2d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .sample_w_i(sample_w), .sample_h_i(sample_h),
    .row_pos_i(row_pos), .col_pos_i(col_pos), .pix_value_i(pix_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .max_value_o(max_value), .max_index_o(max_index), .status_o(status)
  );

  fmp_scoreboard u_check (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .sample_w_i(sample_w), .sample_h_i(sample_h),
    .row_pos_i(row_pos), .col_pos_i(col_pos), .pix_value_i(pix_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .max_value_i(max_value), .max_index_i(max_index), .status_i(status),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stall per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one request beat; called at a rising edge, returns at the accepting edge
  task automatic send_beat(logic [1:0] kind, logic [15:0] sw, logic [15:0] sh,
                           logic [5:0] r, logic [5:0] c, logic [15:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    sample_w  <= sw;
    sample_h  <= sh;
    row_pos   <= r;
    col_pos   <= c;
    pix_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic query(int unsigned r, int unsigned c);
    send_beat(fmp_pkg::REQ_QUERY, 16'($urandom), 16'($urandom), 6'(r), 6'(c),
              16'($urandom));
  endtask

  task automatic pixel(int unsigned r, int unsigned c, logic [15:0] v);
    send_beat(fmp_pkg::REQ_PIXEL, 16'($urandom), 16'($urandom), 6'(r), 6'(c), v);
  endtask

  task automatic sample(logic [15:0] sw, logic [15:0] sh);
    send_beat(fmp_pkg::REQ_SAMPLE, sw, sh, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  // wait for the block to go idle, then write all six size registers
  task automatic set_sizes(int ih, int iw, int oh, int ow, int ph, int pw);
    int vals [6];
    vals = '{ih, iw, oh, ow, ph, pw};
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);   // sample and pixel beats leave no result
    for (int k = 0; k < 6; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= k[2:0];
      cfg_data <= vals[k][6:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_oh = 32'(oh);
    cur_ow = 32'(ow);
  endtask

  function automatic int unsigned pick_pos(int unsigned n);
    if (n == 0 || n > 64 || $urandom_range(0, 99) < 12) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int n_items, bit resample);
    int pick;
    if (resample) sample(16'($urandom), 16'($urandom));
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      query(pick_pos(cur_oh), pick_pos(cur_ow));
      else if (pick < 90) pixel($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      else if (pick < 97) sample(16'($urandom), 16'($urandom));
      else                send_beat(REQ_NONE, 16'($urandom), 16'($urandom), 6'($urandom),
                                    6'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int ih, iw, ph, pw;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; req_type = REQ_NONE;
    sample_w = '0; sample_h = '0; row_pos = '0; col_pos = '0; pix_value = '0;
    out_stall = 1'b0;
    idle_pct = 0; stall_pct = 0; quiet = 0;
    cur_oh = 32; cur_ow = 32;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the corner so every window of a valid size reads written words
    for (int r = 0; r < FILL_SIZE; r++)
      for (int c = 0; c < FILL_SIZE; c++)
        pixel(r, c, pick_value());

    // directed run on a 32x32 plane
    set_sizes(32, 32, 16, 16, 2, 2);
    query(0, 0);                      // steps still zero before any sample
    query(15, 15);
    sample(16'h0000, 16'h0000);
    query(0, 0);
    query(15, 15);
    query(16, 0);                     // row out of range
    query(0, 16);                     // column out of range
    query(63, 63);
    sample(16'hFFFF, 16'hFFFF);
    query(7, 8);
    query(14, 14);
    send_beat(REQ_NONE, 16'hFFFF, 16'hFFFF, 6'h3F, 6'h3F, 16'hFFFF);
    // window of only most negative values gives index -1
    pixel(0, 0, 16'h8000);
    pixel(0, 1, 16'h8000);
    pixel(1, 0, 16'h8000);
    pixel(1, 1, 16'h8000);
    query(0, 0);
    pixel(31, 31, 16'h7FFF);
    query(15, 15);
    pixel(1, 1, 16'h7FFF);
    query(0, 0);
    sample(16'h8000, 16'h1234);
    query(9, 5);

    // phases of sizes and idling; bad sizes and stale steps included
    for (int p = 0; p < 18; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      case (p)
        0: set_sizes(32, 32, 32, 32, 1, 1);
        1: set_sizes(1, 1, 1, 1, 1, 1);
        2: set_sizes(32, 32, 17, 17, 16, 16);
        3: set_sizes(32, 32, 1, 1, 16, 16);
        4: set_sizes(0, 64, 32, 32, 2, 2);        // input rows zero
        5: set_sizes(64, 64, 64, 64, 2, 2);       // window runs past the plane
        6: set_sizes(127, 127, 127, 127, 31, 31); // every register over range
        7: set_sizes(64, 64, 32, 32, 17, 2);      // window too tall
        8: set_sizes(64, 64, 0, 32, 2, 2);        // no output rows
        default: begin
          ih = $urandom_range(1, FILL_SIZE);
          iw = $urandom_range(1, FILL_SIZE);
          ph = $urandom_range(1, (ih < 16) ? ih : 16);
          pw = $urandom_range(1, (iw < 16) ? iw : 16);
          set_sizes(ih, iw, $urandom_range(1, ih - ph + 1), $urandom_range(1, iw - pw + 1),
                    ph, pw);
        end
      endcase
      // every third phase keeps the old steps for a while
      if (p % 3 == 2) run_phase(15, 1'b0);
      run_phase(25, 1'b1);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
